// File: src/assert_macros.svh
// Assertion macros shared by the RTL of the multi-stack store.
// Depends on a clock named clk and a synchronous reset named rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, outside reset
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Check that a condition never holds, outside reset
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) else $error(msg);

`endif

// File: src/mss_pkg.sv
// Package for the multi-stack shared store: defaults, codes and payload types.
// No dependencies.
`default_nettype none

package mss_pkg;

  // Default sizing handed to the top level
  localparam int ENTRIES_DEF    = 16;
  localparam int STACKS_DEF     = 4;
  localparam int DATA_WIDTH_DEF = 32;

  // Fixed field widths of the transactions
  localparam int SID_W    = 2;
  localparam int VALUE_W  = 32;
  localparam int STATUS_W = 2;

  // Operation codes
  localparam logic OP_PUSH = 1'b0;
  localparam logic OP_POP  = 1'b1;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

  typedef struct packed {
    logic               kind;
    logic [SID_W-1:0]   stack_id;
    logic [VALUE_W-1:0] push_value;
  } cmd_t;

  typedef struct packed {
    logic [VALUE_W-1:0]  pop_value;
    logic [STATUS_W-1:0] status;
  } rsp_t;

endpackage

`default_nettype wire

// File: src/mss_chan_if.sv
// Valid/ready channel carrying one payload of a given type per transaction.
// Used with the payload types of mss_pkg.
`default_nettype none

interface mss_chan_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// File: src/multi_stack_shared_store_unit.sv
// Several LIFO stacks sharing one entry store with a free list (mss_pkg, mss_chan_if).
// Response: registered on commit in S_EXEC, after the command is taken in S_IDLE;
// commit waits while the previous response is not taken. A new command is taken only
// in S_IDLE, after the read of the link/data memories and the write-back of the last.
// Reset (rst, synchronous): all stacks empty, free list 0..ENTRIES-1 in order, no
// clearing pass (a fill mark stands in for the initial links); data is undefined.
`default_nettype none

`include "assert_macros.svh"

module multi_stack_shared_store_unit
  import mss_pkg::*;
#(
  parameter int ENTRIES    = ENTRIES_DEF,
  parameter int STACKS     = STACKS_DEF,
  parameter int DATA_WIDTH = DATA_WIDTH_DEF
) (
  input  wire         clk,
  input  wire         rst,
  mss_chan_if.sink    cmd,
  mss_chan_if.source  rsp
);

  // Index width holds ENTRIES itself as the "none" mark
  localparam int IW = $clog2(ENTRIES + 1);
  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int SW = (STACKS > 1) ? $clog2(STACKS) : 1;
  localparam logic [IW-1:0] IDX_NONE = IW'(ENTRIES);

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  // Control state
  logic          state;
  logic [IW-1:0] free_head;
  logic [IW-1:0] wm;            // entries at or above this were never allocated
  logic [IW-1:0] heads [STACKS];
  logic          out_valid;

  // Operation held across the read cycle
  logic                  op_q;
  logic [SW-1:0]         sid_q;
  logic [DATA_WIDTH-1:0] value_q;
  logic [IW-1:0]         slot_q;
  logic                  fail_q;

  // Memories and their registered read data
  logic [IW-1:0]         link_mem [ENTRIES];
  logic [DATA_WIDTH-1:0] data_mem [ENTRIES];
  logic [IW-1:0]         link_rd;
  logic [DATA_WIDTH-1:0] data_rd;

  logic                  accept;
  logic                  commit;
  logic                  sid_ok;
  logic [SW-1:0]         sid_idx;
  logic [IW-1:0]         head_cur;
  logic [IW-1:0]         slot;
  logic                  fail;
  logic                  fresh;
  logic [IW-1:0]         link_eff;
  logic [IW-1:0]         link_wr;
  logic [IW-1:0]         head_next;
  logic [IW-1:0]         free_head_next;
  logic [IW-1:0]         wm_next;
  rsp_t                  rsp_q;

  assign cmd.ready   = (state == S_IDLE);
  assign rsp.valid   = out_valid;
  assign rsp.payload = rsp_q;

  assign accept = cmd.valid && cmd.ready;
  assign commit = (state == S_EXEC) && (!out_valid || rsp.ready);

  // Decode the command and pick the entry it touches
  always_comb begin
    sid_ok   = (32'(cmd.payload.stack_id) < 32'(STACKS));
    sid_idx  = SW'(cmd.payload.stack_id);
    head_cur = sid_ok ? heads[sid_idx] : IDX_NONE;
    if (cmd.payload.kind == OP_PUSH) begin
      slot = free_head;
      fail = !sid_ok || (free_head == IDX_NONE);
    end else begin
      slot = head_cur;
      fail = (head_cur == IDX_NONE);
    end
  end

  // Work out the write-back from the read data
  always_comb begin
    fresh    = (slot_q == wm);
    link_eff = fresh ? (slot_q + IW'(1)) : link_rd;
    if (op_q == OP_PUSH) begin
      link_wr        = heads[sid_q];
      head_next      = slot_q;
      free_head_next = link_eff;
      wm_next        = fresh ? (wm + IW'(1)) : wm;
    end else begin
      link_wr        = free_head;
      head_next      = link_rd;
      free_head_next = slot_q;
      wm_next        = wm;
    end
  end

  // Sequence the idle and execute states and update the list heads
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      free_head <= '0;
      wm        <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < STACKS; i++) begin
        heads[i] <= IDX_NONE;
      end
    end else begin
      if (out_valid && rsp.ready && !commit) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          if (commit) begin
            state     <= S_IDLE;
            out_valid <= 1'b1;
            if (!fail_q) begin
              free_head    <= free_head_next;
              wm           <= wm_next;
              heads[sid_q] <= head_next;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Hold the command for the write-back cycle
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q    <= cmd.payload.kind;
      sid_q   <= sid_idx;
      value_q <= DATA_WIDTH'(cmd.payload.push_value);
      slot_q  <= slot;
      fail_q  <= fail;
    end
  end

  // Load the response register
  always_ff @(posedge clk) begin
    if (commit) begin
      if (fail_q) begin
        rsp_q.pop_value <= '0;
        rsp_q.status    <= (op_q == OP_PUSH) ? ST_FULL : ST_EMPTY;
      end else begin
        rsp_q.status    <= ST_OK;
        rsp_q.pop_value <= (op_q == OP_POP) ? VALUE_W'(data_rd) : '0;
      end
    end
  end

  // Link memory: read on accept, write back on a successful commit
  always_ff @(posedge clk) begin
    if (accept) begin
      link_rd <= link_mem[AW'(slot)];
    end
    if (commit && !fail_q) begin
      link_mem[AW'(slot_q)] <= link_wr;
    end
  end

  // Data memory: read on accept, write on a successful push
  always_ff @(posedge clk) begin
    if (accept) begin
      data_rd <= data_mem[AW'(slot)];
    end
    if (commit && !fail_q && (op_q == OP_PUSH)) begin
      data_mem[AW'(slot_q)] <= value_q;
    end
  end

  // Checks
  `ASSERT_CLK(a_wm_range, wm <= IDX_NONE, "fill mark beyond store size")
  `ASSERT_CLK(a_pop_written,
    (state == S_EXEC && op_q == OP_POP && !fail_q) |-> (slot_q < wm),
    "pop of an entry that was never allocated")
  `ASSERT_CLK(a_full_refused,
    (accept && cmd.payload.kind == OP_PUSH && free_head == IDX_NONE) |=> fail_q,
    "push into a full store not refused")
  `ASSERT_CLK(a_one_at_a_time, accept |=> !cmd.ready,
    "new command taken during write-back")

endmodule

`default_nettype wire

// File: bench/mss_store_checker.sv
// Scoreboard for the multi-stack shared store: watches both channels, predicts each response.
// Depends on mss_pkg for payload types, codes and default sizing.

module mss_store_checker
  import mss_pkg::*;
(
  input  wire  clk,
  input  wire  rst,
  input  wire  cmd_valid,
  input  wire  cmd_ready,
  input  cmd_t cmd_item,
  input  wire  rsp_valid,
  input  wire  rsp_ready,
  input  rsp_t rsp_item,
  output int   fail_count,
  output int   pending,
  output int   push_count,
  output int   full_count,
  output int   pop_count,
  output int   empty_count
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NUM_SLOTS  = ENTRIES_DEF;
  localparam int NUM_STACKS = STACKS_DEF;
  localparam int IDX_W      = $clog2(NUM_SLOTS + 1);
  // One past the last slot marks an empty link or head
  localparam logic [IDX_W-1:0]   NO_SLOT   = IDX_W'(NUM_SLOTS);
  localparam logic [VALUE_W-1:0] WORD_MASK = {VALUE_W{1'b1}} >> (VALUE_W - DATA_WIDTH_DEF);

  // Shadow copy of the store
  logic [VALUE_W-1:0] slot_word [NUM_SLOTS];
  logic [IDX_W-1:0]   slot_next [NUM_SLOTS];
  logic [IDX_W-1:0]   top_slot  [NUM_STACKS];
  logic [IDX_W-1:0]   free_top;

  rsp_t awaited [$];
  rsp_t want;

  // Rebuild the free chain in order and empty every stack
  function automatic void clear_store();
    for (int i = 0; i < NUM_SLOTS; i++) begin
      slot_word[i] = '0;
      slot_next[i] = IDX_W'(i + 1);
    end
    for (int s = 0; s < NUM_STACKS; s++) begin
      top_slot[s] = NO_SLOT;
    end
    free_top = '0;
  endfunction

  // Apply one push or pop to the shadow store and return the response it must give
  function automatic rsp_t apply_stack_op(cmd_t op);
    rsp_t             res;
    logic [IDX_W-1:0] slot;
    int               sid;
    res        = '0;
    res.status = ST_OK;
    sid        = int'(op.stack_id);
    if (op.kind == OP_PUSH) begin
      if (sid >= NUM_STACKS || free_top == NO_SLOT) begin
        res.status = ST_FULL;
      end else begin
        slot            = free_top;
        free_top        = slot_next[slot];
        slot_next[slot] = top_slot[sid];
        slot_word[slot] = op.push_value & WORD_MASK;
        top_slot[sid]   = slot;
      end
    end else begin
      if (sid >= NUM_STACKS || top_slot[sid] == NO_SLOT) begin
        res.status = ST_EMPTY;
      end else begin
        slot            = top_slot[sid];
        top_slot[sid]   = slot_next[slot];
        slot_next[slot] = free_top;
        free_top        = slot;
        res.pop_value   = slot_word[slot] & WORD_MASK;
      end
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    fail_count++;
  endtask

  // Check responses against the oldest prediction, then predict for new commands
  always @(posedge clk) begin
    if (rst) begin
      clear_store();
      awaited.delete();
      pending     = 0;
      fail_count  = 0;
      push_count  = 0;
      full_count  = 0;
      pop_count   = 0;
      empty_count = 0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited.size() == 0) begin
          report_mismatch($sformatf("response (value %h, status %0d) with no command outstanding",
                                    rsp_item.pop_value, rsp_item.status));
        end else begin
          want = awaited.pop_front();
          if (rsp_item.pop_value !== want.pop_value)
            report_mismatch($sformatf("pop_value %h, predicted %h",
                                      rsp_item.pop_value, want.pop_value));
          if (rsp_item.status !== want.status)
            report_mismatch($sformatf("status %0d, predicted %0d",
                                      rsp_item.status, want.status));
        end
      end
      if (cmd_valid && cmd_ready) begin
        want = apply_stack_op(cmd_item);
        awaited.push_back(want);
        case (want.status)
          ST_FULL:  full_count++;
          ST_EMPTY: empty_count++;
          default: begin
            if (cmd_item.kind == OP_PUSH) push_count++;
            else pop_count++;
          end
        endcase
      end
      pending = awaited.size();
    end
  end

endmodule

// File: bench/tb_top.sv
// Top of the multi-stack shared store bench: clock, reset, stimulus, stalls and verdict.
// Depends on mss_pkg, mss_chan_if, multi_stack_shared_store_unit and mss_store_checker.

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mss_pkg::*;

  localparam int ITEM_TARGET = 1450;
  localparam int QUIET_LIMIT = 200;
  localparam int DRAIN_WAIT  = 8;

  logic clk;
  logic rst;

  mss_chan_if #(.T(cmd_t)) cmd_if ();
  mss_chan_if #(.T(rsp_t)) rsp_if ();

  int fail_count, pending, push_count, full_count, pop_count, empty_count;
  int sent;
  int send_burst;
  int take_burst;

  multi_stack_shared_store_unit i_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_if),
    .rsp (rsp_if)
  );

  mss_store_checker i_chk (
    .clk         (clk),
    .rst         (rst),
    .cmd_valid   (cmd_if.valid),
    .cmd_ready   (cmd_if.ready),
    .cmd_item    (cmd_if.payload),
    .rsp_valid   (rsp_if.valid),
    .rsp_ready   (rsp_if.ready),
    .rsp_item    (rsp_if.payload),
    .fail_count  (fail_count),
    .pending     (pending),
    .push_count  (push_count),
    .full_count  (full_count),
    .pop_count   (pop_count),
    .empty_count (empty_count)
  );

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Draw a random idle gap, with occasional runs of back-to-back traffic
  function automatic int draw_gap(inout int burst_left);
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 39) == 0) begin
      burst_left = $urandom_range(15, 50);
      return 0;
    end
    return $urandom_range(0, 3);
  endfunction

  // Offer one command after a random gap and hold it until the transaction completes
  task automatic send_op(input logic op_kind, input logic [SID_W-1:0] sid,
                         input logic [VALUE_W-1:0] value);
    cmd_t item;
    int   gap;
    item = '{kind: op_kind, stack_id: sid, push_value: value};
    gap  = draw_gap(send_burst);
    for (int i = 0; i < gap; i++) begin
      @(negedge clk);
      cmd_if.valid <= 1'b0;
    end
    @(negedge clk);
    cmd_if.valid   <= 1'b1;
    cmd_if.payload <= item;
    do @(posedge clk); while (!(cmd_if.valid && cmd_if.ready));
    sent++;
  endtask

  // Response side: stall at random between transactions
  initial begin
    int gap;
    gap          = 0;
    take_burst   = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (gap > 0) begin
        rsp_if.ready <= 1'b0;
        gap--;
      end else begin
        rsp_if.ready <= 1'b1;
        @(posedge clk);
        if (rsp_if.valid) gap = draw_gap(take_burst);
      end
    end
  end

  // Watchdog: give up when no transaction moves for too long
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (rst || (cmd_if.valid && cmd_if.ready) || (rsp_if.valid && rsp_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("no transaction for %0d cycles, giving up", QUIET_LIMIT);
    $display("FAIL multi_stack_shared_store_unit");
    $finish;
  end

  // Stimulus and verdict
  initial begin
    int   seg_len;
    int   push_pct;
    int   focus_sid;
    bit   focus;
    sent           = 0;
    send_burst     = 0;
    rst            = 1'b1;
    cmd_if.valid   = 1'b0;
    cmd_if.payload = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Directed: empty pops, extreme words, fill the store, refuse a push, reuse a freed slot
    send_op(OP_POP,  2'd0, 32'h1234_5678);
    send_op(OP_PUSH, 2'd0, 32'h0000_0000);
    send_op(OP_PUSH, 2'd3, 32'hFFFF_FFFF);
    send_op(OP_POP,  2'd3, 32'h0000_0000);
    send_op(OP_POP,  2'd0, 32'hFFFF_FFFF);
    send_op(OP_POP,  2'd3, 32'h0000_0000);
    for (int i = 0; i < 16; i++) begin
      send_op(OP_PUSH, SID_W'(i), i[0] ? ~(32'h1 << i) : (32'h1 << (31 - i)));
    end
    send_op(OP_PUSH, 2'd1, 32'hDEAD_BEEF);
    send_op(OP_POP,  2'd2, 32'h0000_0000);
    send_op(OP_PUSH, 2'd2, 32'h8000_0001);

    // Random: segments that lean towards filling, draining or churning the store
    while (sent < ITEM_TARGET) begin
      seg_len = $urandom_range(10, 60);
      case ($urandom_range(0, 3))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      focus     = ($urandom_range(0, 3) == 0);
      focus_sid = $urandom_range(0, 3);
      repeat (seg_len) begin
        send_op(($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP,
                focus ? SID_W'(focus_sid) : SID_W'($urandom_range(0, 3)),
                ($urandom_range(0, 9) == 0) ? {VALUE_W{1'($urandom_range(0, 1))}}
                                            : VALUE_W'($urandom));
      end
    end

    // Drop valid, drain outstanding responses, then watch for strays
    @(negedge clk);
    cmd_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (DRAIN_WAIT) @(negedge clk);

    $display("%0d commands: %0d pushes stored, %0d refused on a full store,", sent,
             push_count, full_count);
    $display("  %0d pops returned data, %0d hit an empty stack", pop_count, empty_count);
    if (fail_count == 0) begin
      $display("PASS multi_stack_shared_store_unit");
    end else begin
      $display("FAIL multi_stack_shared_store_unit");
    end
    $finish;
  end

endmodule
